// ===== rtl/core/pfn_pkg.sv =====
// Shared types and constants for the polygon face normal block.
package pfn_pkg;

  localparam int MAX_POLY_VERTS_DEF = 256;
  localparam int COORD_WIDTH_DEF    = 24;
  localparam int SUM_W              = 58;
  localparam int NORM_W             = 32;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_EDGE_MUL,
    OP_EDGE_ACC,
    OP_MAG,
    OP_SHR,
    OP_SHL,
    OP_SQ_MUL,
    OP_SQ_ACC,
    OP_SQRT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_STORE,
    OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] comp;
    logic       close_edge;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic mag_zero;
    logic need_shr;
    logic need_shl;
  } dp_stat_t;

endpackage

// ===== rtl/core/polygon_face_normal.sv =====
// Top level of the Newell polygon face normal block.
// Each vertex word taken while idle adds its edge term; the first word adds none.
// The last word also closes the loop, scans the sums, shifts them one bit a cycle until the
// largest has its top set bit at bit 30, squares, runs a root and three divides, then gives
// its normal; a degenerate polygon, such as a lone vertex, goes from the scan to the result.
// Synchronous active-low reset clears the sums, count and output valid.
module polygon_face_normal #(
  parameter int MAX_POLY_VERTS = pfn_pkg::MAX_POLY_VERTS_DEF,
  parameter int COORD_WIDTH    = pfn_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_y,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_z,
  input  logic                          in_last_vertex,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [pfn_pkg::NORM_W-1:0] out_normal_x,
  output logic signed [pfn_pkg::NORM_W-1:0] out_normal_y,
  output logic signed [pfn_pkg::NORM_W-1:0] out_normal_z,
  output logic                          out_degenerate,
  output logic                          out_too_many_vertices
);
  import pfn_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Controller.
  pfn_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_last_vertex (in_last_vertex),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .stat           (stat),
    .cmd            (cmd)
  );

  // Datapath.
  pfn_datapath #(
    .MAX_POLY_VERTS (MAX_POLY_VERTS),
    .COORD_WIDTH    (COORD_WIDTH)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .in_vertex_x           (in_vertex_x),
    .in_vertex_y           (in_vertex_y),
    .in_vertex_z           (in_vertex_z),
    .stat                  (stat),
    .out_normal_x          (out_normal_x),
    .out_normal_y          (out_normal_y),
    .out_normal_z          (out_normal_z),
    .out_degenerate        (out_degenerate),
    .out_too_many_vertices (out_too_many_vertices)
  );

endmodule

// ===== rtl/core/pfn_ctrl.sv =====
// Sequencing controller for the polygon face normal block.
module pfn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_last_vertex,
  output logic              out_valid,
  input  logic              out_ready,
  input  pfn_pkg::dp_stat_t stat,
  output pfn_pkg::dp_cmd_t  cmd
);
  import pfn_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EDGE_MUL, S_EDGE_ACC, S_MAG, S_SHIFT, S_SQ_MUL, S_SQ_ACC,
    S_SQRT, S_DIV_INIT, S_DIV_STEP, S_DIV_STORE, S_FINISH
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [4:0] iter_r, iter_nxt;
  logic       close_r, close_nxt;
  logic       last_r, last_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and datapath command.
  always_comb begin
    state_nxt      = state_r;
    comp_nxt       = comp_r;
    iter_nxt       = iter_r;
    close_nxt      = close_r;
    last_nxt       = last_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    cmd.op         = OP_NONE;
    cmd.comp       = comp_r;
    cmd.close_edge = close_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          last_nxt  = in_last_vertex;
          comp_nxt  = 2'd0;
          if (stat.count_zero) begin
            close_nxt = 1'b1;
            state_nxt = in_last_vertex ? S_EDGE_MUL : S_IDLE;
          end else begin
            close_nxt = 1'b0;
            state_nxt = S_EDGE_MUL;
          end
        end
      end
      S_EDGE_MUL: begin
        cmd.op    = OP_EDGE_MUL;
        state_nxt = S_EDGE_ACC;
      end
      S_EDGE_ACC: begin
        cmd.op = OP_EDGE_ACC;
        if (comp_r != 2'd2) begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_EDGE_MUL;
        end else begin
          comp_nxt = 2'd0;
          if (close_r) begin
            state_nxt = S_MAG;
          end else if (last_r) begin
            close_nxt = 1'b1;
            state_nxt = S_EDGE_MUL;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_MAG: begin
        cmd.op    = OP_MAG;
        state_nxt = S_SHIFT;
      end
      S_SHIFT: begin
        if (stat.mag_zero) begin
          state_nxt = S_FINISH;
        end else if (stat.need_shr) begin
          cmd.op = OP_SHR;
        end else if (stat.need_shl) begin
          cmd.op = OP_SHL;
        end else begin
          comp_nxt  = 2'd0;
          state_nxt = S_SQ_MUL;
        end
      end
      S_SQ_MUL: begin
        cmd.op    = OP_SQ_MUL;
        state_nxt = S_SQ_ACC;
      end
      S_SQ_ACC: begin
        cmd.op = OP_SQ_ACC;
        if (comp_r != 2'd2) begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_SQ_MUL;
        end else begin
          comp_nxt  = 2'd0;
          iter_nxt  = 5'd31;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.op   = OP_SQRT;
        iter_nxt = iter_r - 5'd1;
        if (iter_r == 5'd0) begin
          state_nxt = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd.op    = OP_DIV_INIT;
        iter_nxt  = 5'd30;
        state_nxt = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd.op   = OP_DIV_STEP;
        iter_nxt = iter_r - 5'd1;
        if (iter_r == 5'd0) begin
          state_nxt = S_DIV_STORE;
        end
      end
      S_DIV_STORE: begin
        cmd.op = OP_DIV_STORE;
        if (comp_r != 2'd2) begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_DIV_INIT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // Hold the finished normal until the output register is free.
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, counters and the registered output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      comp_r      <= 2'd0;
      iter_r      <= 5'd0;
      close_r     <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      comp_r      <= comp_nxt;
      iter_r      <= iter_nxt;
      close_r     <= close_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/core/pfn_datapath.sv =====
// Accumulation, normalisation, square root and divide datapath.
module pfn_datapath #(
  parameter int MAX_POLY_VERTS = pfn_pkg::MAX_POLY_VERTS_DEF,
  parameter int COORD_WIDTH    = pfn_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pfn_pkg::dp_cmd_t              cmd,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_x,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_y,
  input  logic signed [COORD_WIDTH-1:0] in_vertex_z,
  output pfn_pkg::dp_stat_t             stat,
  output logic signed [pfn_pkg::NORM_W-1:0] out_normal_x,
  output logic signed [pfn_pkg::NORM_W-1:0] out_normal_y,
  output logic signed [pfn_pkg::NORM_W-1:0] out_normal_z,
  output logic                          out_degenerate,
  output logic                          out_too_many_vertices
);
  import pfn_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int PROD_W = 2 * CW + 2;
  localparam int ACC_W  = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;
  localparam int CNT_W  = $clog2(MAX_POLY_VERTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POLY_VERTS);
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

  logic signed [CW-1:0]     first_r [3];
  logic signed [CW-1:0]     prev_r  [3];
  logic signed [CW-1:0]     cur_r   [3];
  logic signed [SUM_W-1:0]  sum_r   [3];
  logic [CNT_W-1:0]         count_r;
  logic                     ovf_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]         mag_r   [3];
  logic [SUM_W-1:0]         m_r;
  logic [2:0]               neg_r;
  logic [61:0]              sqp_r;
  logic [63:0]              q_r;
  logic [34:0]              srem_r;
  logic [31:0]              res_r;
  logic [31:0]              drem_r;
  logic [30:0]              dlow_r;
  logic [30:0]              quo_r;
  logic signed [NORM_W-1:0] nrm_r   [3];
  logic signed [NORM_W-1:0] nx_r, ny_r, nz_r;
  logic                     degen_r, tmv_r;

  logic signed [CW-1:0]     ea [3];
  logic signed [CW-1:0]     eb [3];
  logic [1:0]               i1, i2;
  logic signed [CW:0]       diff_c, add_c;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [ACC_W-1:0]  acc_c;
  logic signed [SUM_W-1:0]  acc_sat;
  logic                     acc_ovf;
  logic [SUM_W-1:0]         magc [3];
  logic [SUM_W-1:0]         mx01, mxc;
  logic [34:0]              rem_sh, trial;
  logic [61:0]              numer;
  logic [32:0]              dtry;
  logic                     dge;

  assign out_normal_x          = nx_r;
  assign out_normal_y          = ny_r;
  assign out_normal_z          = nz_r;
  assign out_degenerate        = degen_r;
  assign out_too_many_vertices = tmv_r;

  // Edge endpoints: previous to current, or current back to the first vertex.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ea[k] = cmd.close_edge ? cur_r[k]   : prev_r[k];
      eb[k] = cmd.close_edge ? first_r[k] : cur_r[k];
    end
    case (cmd.comp)
      2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
      2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
      default: begin i1 = 2'd0; i2 = 2'd1; end
    endcase
  end

  // Newell term for one component and the saturating sum.
  assign diff_c = {ea[i1][CW-1], ea[i1]} - {eb[i1][CW-1], eb[i1]};
  assign add_c  = {ea[i2][CW-1], ea[i2]} + {eb[i2][CW-1], eb[i2]};
  assign prod_c = diff_c * add_c;
  assign acc_c  = ACC_W'(sum_r[cmd.comp]) + ACC_W'(prod_r);

  always_comb begin
    acc_ovf = 1'b0;
    acc_sat = acc_c[SUM_W-1:0];
    if (acc_c > SAT_HI) begin
      acc_sat = SAT_HI[SUM_W-1:0];
      acc_ovf = 1'b1;
    end else if (acc_c < SAT_LO) begin
      acc_sat = SAT_LO[SUM_W-1:0];
      acc_ovf = 1'b1;
    end
  end

  // Magnitudes of the sums and their maximum.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      magc[k] = sum_r[k][SUM_W-1] ? SUM_W'(-sum_r[k]) : SUM_W'(sum_r[k]);
    end
    mx01 = (magc[0] > magc[1]) ? magc[0] : magc[1];
    mxc  = (mx01 > magc[2]) ? mx01 : magc[2];
  end

  assign stat.count_zero = (count_r == '0);
  assign stat.mag_zero   = (m_r == '0);
  assign stat.need_shr   = |m_r[SUM_W-1:31];
  assign stat.need_shl   = !(|m_r[SUM_W-1:31]) && !m_r[30];

  // One root digit per cycle.
  assign rem_sh = {srem_r[32:0], q_r[63:62]};
  assign trial  = {1'b0, res_r, 2'b01};

  // Rounded dividend and one restoring divide step.
  assign numer = {mag_r[cmd.comp][30:0], 30'd0} + 62'(res_r[31:1]);
  assign dtry  = {drem_r, dlow_r[30]};
  assign dge   = (dtry >= {1'b0, res_r});

  // Register updates per command.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        sum_r[k] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          prev_r <= cur_r;
          cur_r[0] <= in_vertex_x;
          cur_r[1] <= in_vertex_y;
          cur_r[2] <= in_vertex_z;
          if (count_r == '0) begin
            first_r[0] <= in_vertex_x;
            first_r[1] <= in_vertex_y;
            first_r[2] <= in_vertex_z;
          end
          if (count_r >= CNT_MAX) begin
            ovf_r <= 1'b1;
          end else begin
            count_r <= count_r + CNT_W'(1);
          end
        end
        OP_EDGE_MUL: prod_r <= prod_c;
        OP_EDGE_ACC: begin
          sum_r[cmd.comp] <= acc_sat;
          if (acc_ovf) begin
            ovf_r <= 1'b1;
          end
        end
        OP_MAG: begin
          for (int k = 0; k < 3; k++) begin
            mag_r[k] <= magc[k];
            neg_r[k] <= sum_r[k][SUM_W-1];
          end
          m_r    <= mxc;
          q_r    <= '0;
          srem_r <= '0;
          res_r  <= '0;
        end
        OP_SHR: begin
          for (int k = 0; k < 3; k++) begin
            mag_r[k] <= mag_r[k] >> 1;
          end
          m_r <= m_r >> 1;
        end
        OP_SHL: begin
          for (int k = 0; k < 3; k++) begin
            mag_r[k] <= mag_r[k] << 1;
          end
          m_r <= m_r << 1;
        end
        OP_SQ_MUL: sqp_r <= mag_r[cmd.comp][30:0] * mag_r[cmd.comp][30:0];
        OP_SQ_ACC: q_r <= q_r + {2'b00, sqp_r};
        OP_SQRT: begin
          q_r <= {q_r[61:0], 2'b00};
          if (rem_sh >= trial) begin
            srem_r <= rem_sh - trial;
            res_r  <= {res_r[30:0], 1'b1};
          end else begin
            srem_r <= rem_sh;
            res_r  <= {res_r[30:0], 1'b0};
          end
        end
        OP_DIV_INIT: begin
          drem_r <= {1'b0, numer[61:31]};
          dlow_r <= numer[30:0];
          quo_r  <= '0;
        end
        OP_DIV_STEP: begin
          drem_r <= dge ? 32'(dtry - {1'b0, res_r}) : dtry[31:0];
          dlow_r <= {dlow_r[29:0], 1'b0};
          quo_r  <= {quo_r[29:0], dge};
        end
        OP_DIV_STORE: begin
          nrm_r[cmd.comp] <= neg_r[cmd.comp] ? -{1'b0, quo_r} : {1'b0, quo_r};
        end
        OP_FINISH: begin
          if (m_r == '0) begin
            nx_r    <= '0;
            ny_r    <= '0;
            nz_r    <= '0;
            degen_r <= 1'b1;
          end else begin
            nx_r    <= nrm_r[0];
            ny_r    <= nrm_r[1];
            nz_r    <= nrm_r[2];
            degen_r <= 1'b0;
          end
          tmv_r   <= ovf_r;
          count_r <= '0;
          ovf_r   <= 1'b0;
          for (int k = 0; k < 3; k++) begin
            sum_r[k] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/pfn_checker.sv =====
// Port-level assertions for the polygon face normal block, with its bind.
module pfn_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last_vertex,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [pfn_pkg::NORM_W-1:0] out_normal_x,
  input logic signed [pfn_pkg::NORM_W-1:0] out_normal_y,
  input logic signed [pfn_pkg::NORM_W-1:0] out_normal_z,
  input logic                          out_degenerate
);
  import pfn_pkg::*;

  localparam logic signed [NORM_W-1:0] ONE = NORM_W'(1) <<< 30;

  // A stalled result stays valid and holds its x component.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_normal_x))
    else $error("stalled result word changed");

  // The last vertex word starts processing, so no word is taken next cycle.
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last_vertex |=> !in_ready)
    else $error("vertex taken during normalisation");

  // A degenerate result carries a zero normal.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0)
    else $error("degenerate result with non-zero normal");

  // Components stay within unit range.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_normal_x <= ONE && out_normal_x >= -ONE &&
      out_normal_y <= ONE && out_normal_y >= -ONE &&
      out_normal_z <= ONE && out_normal_z >= -ONE)
    else $error("normal component out of range");

endmodule

bind polygon_face_normal pfn_checker u_pfn_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_last_vertex (in_last_vertex),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_normal_x   (out_normal_x),
  .out_normal_y   (out_normal_y),
  .out_normal_z   (out_normal_z),
  .out_degenerate (out_degenerate)
);
